FILE: rtl/core/c3s_pkg.sv
package c3s_pkg;

  // input item kinds
  localparam logic [1:0] KIND_LOAD  = 2'd0;
  localparam logic [1:0] KIND_PIXEL = 2'd1;
  localparam logic [1:0] KIND_FLUSH = 2'd2;

  // configuration register indexes
  localparam logic [1:0] REG_FRAME_WIDTH  = 2'd0;
  localparam logic [1:0] REG_FRAME_HEIGHT = 2'd1;
  localparam logic [1:0] REG_BIAS_VALUE   = 2'd2;
  localparam logic [1:0] REG_RELU_ENABLE  = 2'd3;

  localparam int NUM_COEFS     = 9;
  localparam int MAX_HEIGHT    = 1024;
  localparam int JOBQ_DEPTH    = 4;
  localparam int JOBQ_LVL_BITS = $clog2(JOBQ_DEPTH + 1);

  typedef enum logic [1:0] {
    JOB_LOAD,
    JOB_PIXEL,
    JOB_FLUSH
  } c3s_job_op_t;

  typedef struct packed {
    logic [10:0] frame_width;
    logic [10:0] frame_height;
    logic [31:0] bias_value;
    logic        relu_enable;
  } c3s_cfg_t;

  // control part of one job between front and back
  typedef struct packed {
    c3s_job_op_t op;
    logic [3:0]  idx;
    logic        first_col;
    logic        emit_a;
    logic        emit_b;
    logic        drain_start;
    logic        last;
    logic [9:0]  row_o;
    logic [9:0]  col_o;
  } c3s_jobctl_t;

endpackage

FILE: rtl/core/c3s_ifs.sv
interface c3s_in_if #(
  parameter int SAMPLE_BITS = 16
);
  logic                          valid;
  logic                          ready;
  logic [1:0]                    kind;
  logic [3:0]                    coef_index;
  logic signed [SAMPLE_BITS-1:0] sample;

  modport source (output valid, kind, coef_index, sample, input ready);
  modport sink   (input valid, kind, coef_index, sample, output ready);
endinterface

interface c3s_out_if;
  logic               valid;
  logic               ready;
  logic signed [31:0] conv_result;
  logic [9:0]         out_row;
  logic [9:0]         out_col;
  logic               run_last;
  logic               frame_last;

  modport source (output valid, conv_result, out_row, out_col, run_last, frame_last,
                  input ready);
  modport sink   (input valid, conv_result, out_row, out_col, run_last, frame_last,
                  output ready);
endinterface

FILE: rtl/core/conv3x3_same_relu_stream_top.sv
// channel   dir  payload                                              accepted when
// in_chan   in   kind, coef_index, sample                             valid && ready
// out_chan  out  conv_result, out_row, out_col, run_last, frame_last  valid && ready
// cfg_*     in   cfg_index, cfg_wdata                                 cfg_we
//
// one item per cycle while in_chan.ready is high; a pixel at a row end holds the back end
// for a second result, so once the four-entry job queue is full the input pauses once per row
// a pixel's result passes through stage one, a job queue slot, and the product, partial-sum, sum and output registers
// the line stores are single-port-write, registered-read memories; no clearing pass
// rst_n is synchronous; a stalled output freezes the back pipeline while the front
// keeps accepting until the job queue fills
module conv3x3_same_relu_stream_top #(
  parameter int MAX_WIDTH   = 1024,
  parameter int SAMPLE_BITS = 16
) (
  input  logic        clk,
  input  logic        rst_n,
  c3s_in_if.sink      in_chan,
  c3s_out_if.source   out_chan,
  input  logic        cfg_we,
  input  logic [1:0]  cfg_index,
  input  logic [31:0] cfg_wdata
);
  import c3s_pkg::*;

  localparam int JW = $bits(c3s_jobctl_t) + 3 * SAMPLE_BITS;

  c3s_cfg_t cfg_r;

  logic                     q_push, q_pop, q_not_empty;
  logic [JW-1:0]            q_push_data, q_head;
  logic [JOBQ_LVL_BITS-1:0] q_level;

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      cfg_r.frame_width  <= 11'd240;
      cfg_r.frame_height <= 11'd520;
      cfg_r.bias_value   <= '0;
      cfg_r.relu_enable  <= 1'b1;
    end else if (cfg_we) begin
      unique case (cfg_index)
        REG_FRAME_WIDTH:  cfg_r.frame_width  <= cfg_wdata[10:0];
        REG_FRAME_HEIGHT: cfg_r.frame_height <= cfg_wdata[10:0];
        REG_BIAS_VALUE:   cfg_r.bias_value   <= cfg_wdata;
        REG_RELU_ENABLE:  cfg_r.relu_enable  <= cfg_wdata[0];
      endcase
    end
  end

  c3s_front #(
    .MAX_WIDTH   (MAX_WIDTH),
    .SAMPLE_BITS (SAMPLE_BITS)
  ) u_front (
    .clk     (clk),
    .rst_n   (rst_n),
    .in_chan (in_chan),
    .cfg     (cfg_r),
    .q_level (q_level),
    .q_push  (q_push),
    .q_data  (q_push_data)
  );

  c3s_jobq #(
    .WIDTH (JW),
    .DEPTH (JOBQ_DEPTH)
  ) u_jobq (
    .clk       (clk),
    .rst_n     (rst_n),
    .push      (q_push),
    .push_data (q_push_data),
    .pop       (q_pop),
    .head_data (q_head),
    .not_empty (q_not_empty),
    .level     (q_level)
  );

  c3s_back #(
    .SAMPLE_BITS (SAMPLE_BITS)
  ) u_back (
    .clk      (clk),
    .rst_n    (rst_n),
    .cfg      (cfg_r),
    .q_valid  (q_not_empty),
    .q_data   (q_head),
    .q_pop    (q_pop),
    .out_chan (out_chan)
  );

endmodule

FILE: rtl/core/c3s_ram.sv
module c3s_ram #(
  parameter int WIDTH = 16,
  parameter int DEPTH = 1024
) (
  input  logic                     clk,
  input  logic                     we,
  input  logic [$clog2(DEPTH)-1:0] waddr,
  input  logic [WIDTH-1:0]         wdata,
  input  logic [$clog2(DEPTH)-1:0] raddr,
  output logic [WIDTH-1:0]         rdata
);

  logic [WIDTH-1:0] mem_r [DEPTH];
  logic [WIDTH-1:0] rdata_r;

  always_ff @(posedge clk) begin
    if (we) begin
      mem_r[waddr] <= wdata;
    end
    rdata_r <= mem_r[raddr];
  end

  assign rdata = rdata_r;

endmodule

FILE: rtl/core/c3s_jobq.sv
module c3s_jobq #(
  parameter int WIDTH = 64,
  parameter int DEPTH = 4
) (
  input  logic                       clk,
  input  logic                       rst_n,
  input  logic                       push,
  input  logic [WIDTH-1:0]           push_data,
  input  logic                       pop,
  output logic [WIDTH-1:0]           head_data,
  output logic                       not_empty,
  output logic [$clog2(DEPTH+1)-1:0] level
);

  localparam int PW = $clog2(DEPTH);
  localparam int LW = $clog2(DEPTH + 1);

  logic [WIDTH-1:0] slot_r [DEPTH];
  logic [PW-1:0]    wr_ptr_r, wr_ptr_nxt;
  logic [PW-1:0]    rd_ptr_r, rd_ptr_nxt;
  logic [LW-1:0]    level_r, level_nxt;
  logic             do_pop;

  assign not_empty = (level_r != '0);
  assign do_pop    = pop && not_empty;
  assign head_data = slot_r[rd_ptr_r];
  assign level     = level_r;

  always_comb begin
    wr_ptr_nxt = push   ? wr_ptr_r + PW'(1) : wr_ptr_r;
    rd_ptr_nxt = do_pop ? rd_ptr_r + PW'(1) : rd_ptr_r;
    level_nxt  = level_r + LW'(push) - LW'(do_pop);
  end

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      wr_ptr_r <= '0;
      rd_ptr_r <= '0;
      level_r  <= '0;
    end else begin
      wr_ptr_r <= wr_ptr_nxt;
      rd_ptr_r <= rd_ptr_nxt;
      level_r  <= level_nxt;
    end
  end

  always_ff @(posedge clk) begin
    if (push) begin
      slot_r[wr_ptr_r] <= push_data;
    end
  end

endmodule

FILE: rtl/core/c3s_front.sv
module c3s_front #(
  parameter int MAX_WIDTH   = 1024,
  parameter int SAMPLE_BITS = 16
) (
  input  logic                                   clk,
  input  logic                                   rst_n,
  c3s_in_if.sink                                 in_chan,
  input  c3s_pkg::c3s_cfg_t                      cfg,
  input  logic [c3s_pkg::JOBQ_LVL_BITS-1:0]      q_level,
  output logic                                   q_push,
  output logic [$bits(c3s_pkg::c3s_jobctl_t)+3*SAMPLE_BITS-1:0] q_data
);
  import c3s_pkg::*;

  localparam int SB  = SAMPLE_BITS;
  localparam int CW  = $clog2(MAX_WIDTH);
  localparam int LW  = (CW + 1 > 11) ? CW + 1 : 11;
  localparam int QLW = JOBQ_LVL_BITS + 1;

  // counters and drain state
  logic [CW-1:0] col_r, col_nxt;
  logic [9:0]    row_r, row_nxt;
  logic [CW-1:0] flush_r, flush_nxt;
  logic          drain_r, drain_nxt;

  // stage one: waits for line store read data
  logic           s1_valid_r;
  c3s_jobctl_t    s1_ctl_r;
  logic [SB-1:0]  s1_sample_r;
  logic [CW-1:0]  s1_addr_r;
  logic           s1_r2_r;
  logic           s1_rd_ok_r;
  logic           s1_byp_r;
  logic [SB-1:0]  byp_up_r;
  logic [SB-1:0]  byp_lo_r;

  logic [LW-1:0]  fw, eff_w, w_m1, f1;
  logic [10:0]    eff_h, h_m1;
  logic           row_end, last_row, f_last;
  logic [QLW-1:0] lvl_sum;
  logic           accept, take, byp_hit;
  c3s_jobctl_t    ctl_new;
  logic [CW-1:0]  rd_addr;
  logic           r2_new, rd_ok_new;

  logic [SB-1:0]  up_rd, lo_rd, up_v, lo_v;
  logic [SB-1:0]  d0, d1, d2;
  logic           ram_we;

  always_comb begin
    fw = LW'(cfg.frame_width);
    if (fw < LW'(2)) begin
      eff_w = LW'(2);
    end else if (fw > LW'(MAX_WIDTH)) begin
      eff_w = LW'(MAX_WIDTH);
    end else begin
      eff_w = fw;
    end
    w_m1 = eff_w - LW'(1);

    if (cfg.frame_height < 11'd2) begin
      eff_h = 11'd2;
    end else if (cfg.frame_height > 11'(MAX_HEIGHT)) begin
      eff_h = 11'(MAX_HEIGHT);
    end else begin
      eff_h = cfg.frame_height;
    end
    h_m1 = eff_h - 11'd1;

    row_end  = (LW'(col_r) >= w_m1);
    last_row = ({1'b0, row_r} >= h_m1);
    f1       = LW'(flush_r) + LW'(1);
    f_last   = (f1 >= eff_w);
  end

  // room for the item in flight plus this one
  assign lvl_sum       = QLW'(q_level) + QLW'(s1_valid_r);
  assign in_chan.ready = (lvl_sum < QLW'(JOBQ_DEPTH));
  assign accept        = in_chan.valid && in_chan.ready;

  always_comb begin
    take      = 1'b0;
    ctl_new   = '0;
    rd_addr   = col_r;
    r2_new    = (row_r >= 10'd2);
    rd_ok_new = 1'b0;
    col_nxt   = col_r;
    row_nxt   = row_r;
    flush_nxt = flush_r;
    drain_nxt = drain_r;
    unique case (in_chan.kind)
      KIND_LOAD: begin
        if (in_chan.coef_index < 4'(NUM_COEFS)) begin
          take        = 1'b1;
          ctl_new.op  = JOB_LOAD;
          ctl_new.idx = in_chan.coef_index;
        end
      end
      KIND_PIXEL: begin
        if (!drain_r) begin
          take                = 1'b1;
          ctl_new.op          = JOB_PIXEL;
          ctl_new.first_col   = (col_r == '0);
          ctl_new.emit_a      = (col_r != '0) && (row_r != '0);
          ctl_new.emit_b      = row_end && (row_r != '0);
          ctl_new.drain_start = row_end && last_row;
          ctl_new.row_o       = row_r - 10'd1;
          ctl_new.col_o       = 10'(col_r - CW'(1));
          if (row_end) begin
            col_nxt = '0;
            if (last_row) begin
              drain_nxt = 1'b1;
              flush_nxt = '0;
            end else begin
              row_nxt = row_r + 10'd1;
            end
          end else begin
            col_nxt = col_r + CW'(1);
          end
        end
      end
      KIND_FLUSH: begin
        if (drain_r) begin
          take           = 1'b1;
          ctl_new.op     = JOB_FLUSH;
          ctl_new.emit_a = 1'b1;
          ctl_new.last   = f_last;
          ctl_new.row_o  = row_r;
          ctl_new.col_o  = 10'(flush_r);
          rd_addr        = f1[CW-1:0];
          rd_ok_new      = !f_last;
          if (f_last) begin
            drain_nxt = 1'b0;
            row_nxt   = '0;
            col_nxt   = '0;
            flush_nxt = '0;
          end else begin
            flush_nxt = f1[CW-1:0];
          end
        end
      end
      default: begin
        take = 1'b0;
      end
    endcase
  end

  // the column being written this cycle may be the one read now (width of two)
  assign byp_hit = s1_valid_r && (s1_ctl_r.op == JOB_PIXEL) && (s1_addr_r == rd_addr);

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      col_r      <= '0;
      row_r      <= '0;
      flush_r    <= '0;
      drain_r    <= 1'b0;
      s1_valid_r <= 1'b0;
    end else begin
      if (accept && take) begin
        col_r   <= col_nxt;
        row_r   <= row_nxt;
        flush_r <= flush_nxt;
        drain_r <= drain_nxt;
      end
      s1_valid_r <= accept && take;
    end
  end

  always_ff @(posedge clk) begin
    s1_ctl_r    <= ctl_new;
    s1_sample_r <= in_chan.sample;
    s1_addr_r   <= rd_addr;
    s1_r2_r     <= r2_new;
    s1_rd_ok_r  <= rd_ok_new;
    s1_byp_r    <= byp_hit;
    byp_up_r    <= lo_v;
    byp_lo_r    <= s1_sample_r;
  end

  always_comb begin
    up_v = s1_byp_r ? byp_up_r : up_rd;
    lo_v = s1_byp_r ? byp_lo_r : lo_rd;
    d0   = '0;
    d1   = '0;
    d2   = '0;
    unique case (s1_ctl_r.op)
      JOB_PIXEL: begin
        d0 = s1_r2_r ? up_v : '0;
        d1 = lo_v;
        d2 = s1_sample_r;
      end
      JOB_FLUSH: begin
        d0 = s1_rd_ok_r ? up_v : '0;
        d1 = s1_rd_ok_r ? lo_v : '0;
      end
      default: begin
        d2 = s1_sample_r;
      end
    endcase
  end

  assign ram_we = s1_valid_r && (s1_ctl_r.op == JOB_PIXEL);
  assign q_push = s1_valid_r;
  assign q_data = {s1_ctl_r, d2, d1, d0};

  c3s_ram #(
    .WIDTH (SB),
    .DEPTH (MAX_WIDTH)
  ) u_line_upper (
    .clk   (clk),
    .we    (ram_we),
    .waddr (s1_addr_r),
    .wdata (lo_v),
    .raddr (rd_addr),
    .rdata (up_rd)
  );

  c3s_ram #(
    .WIDTH (SB),
    .DEPTH (MAX_WIDTH)
  ) u_line_lower (
    .clk   (clk),
    .we    (ram_we),
    .waddr (s1_addr_r),
    .wdata (s1_sample_r),
    .raddr (rd_addr),
    .rdata (lo_rd)
  );

endmodule

FILE: rtl/core/c3s_back.sv
module c3s_back #(
  parameter int SAMPLE_BITS = 16
) (
  input  logic                                   clk,
  input  logic                                   rst_n,
  input  c3s_pkg::c3s_cfg_t                      cfg,
  input  logic                                   q_valid,
  input  logic [$bits(c3s_pkg::c3s_jobctl_t)+3*SAMPLE_BITS-1:0] q_data,
  output logic                                   q_pop,
  c3s_out_if.source                              out_chan
);
  import c3s_pkg::*;

  localparam int SB   = SAMPLE_BITS;
  localparam int PW   = 2 * SB;
  localparam int PSW  = PW + 2;
  localparam int SW   = ((PW > 32) ? PW : 32) + 5;
  localparam int CTLW = $bits(c3s_jobctl_t);

  localparam logic signed [SW-1:0] SAT_HI = {{(SW-31){1'b0}}, {31{1'b1}}};
  localparam logic signed [SW-1:0] SAT_LO = {{(SW-31){1'b1}}, {31{1'b0}}};

  typedef struct packed {
    logic [9:0] row;
    logic [9:0] col;
    logic       run_last;
    logic       frame_last;
  } meta_t;

  logic               en, go;
  c3s_jobctl_t        ctl;
  logic signed [SB-1:0] dcol [3];

  logic signed [SB-1:0] win_r [6];
  logic signed [SB-1:0] win_nxt [6];
  logic signed [SB-1:0] coef_r [NUM_COEFS];
  logic signed [SB-1:0] coef_nxt [NUM_COEFS];
  logic signed [SB-1:0] c0a_r, c0a_nxt, c0b_r, c0b_nxt;
  logic                 phase_r, phase_nxt;

  logic                 op_valid, right_zero;
  meta_t                op_meta;
  logic signed [PW-1:0] prod [NUM_COEFS];

  logic                 m_valid_r, p_valid_r, s_valid_r, out_valid_r;
  logic signed [PW-1:0] m_prod_r [NUM_COEFS];
  meta_t                m_meta_r, p_meta_r, s_meta_r;
  logic signed [PSW-1:0] p_sum_r [3];
  logic signed [SW-1:0] s_sum_r;
  logic signed [31:0]   res_sat;
  logic signed [31:0]   conv_r;
  meta_t                out_meta_r;

  // whole back pipeline moves when the output register can take a result
  assign en = !out_valid_r || out_chan.ready;
  assign go = en && q_valid;

  assign ctl     = c3s_jobctl_t'(q_data[3*SB +: CTLW]);
  assign dcol[0] = q_data[0 +: SB];
  assign dcol[1] = q_data[SB +: SB];
  assign dcol[2] = q_data[2*SB +: SB];

  always_comb begin
    win_nxt    = win_r;
    coef_nxt   = coef_r;
    c0a_nxt    = c0a_r;
    c0b_nxt    = c0b_r;
    phase_nxt  = phase_r;
    q_pop      = 1'b0;
    op_valid   = 1'b0;
    right_zero = 1'b0;
    op_meta    = '{row: ctl.row_o, col: ctl.col_o, run_last: 1'b1, frame_last: 1'b0};
    if (go) begin
      unique case (ctl.op)
        JOB_LOAD: begin
          for (int k = 0; k < NUM_COEFS; k++) begin
            if (ctl.idx == 4'(k)) begin
              coef_nxt[k] = dcol[2];
            end
          end
          q_pop = 1'b1;
        end
        JOB_PIXEL: begin
          if (!phase_r) begin
            op_valid         = ctl.emit_a;
            op_meta.run_last = !ctl.emit_b;
            if (ctl.first_col) begin
              for (int k = 0; k < 3; k++) begin
                win_nxt[k]     = '0;
                win_nxt[3 + k] = dcol[k];
              end
              // keep column zero of the row for the bottom-row drain
              c0a_nxt = dcol[1];
              c0b_nxt = dcol[2];
            end else begin
              for (int k = 0; k < 3; k++) begin
                win_nxt[k]     = win_r[3 + k];
                win_nxt[3 + k] = dcol[k];
              end
            end
            if (ctl.emit_b) begin
              phase_nxt = 1'b1;
            end else begin
              q_pop = 1'b1;
            end
          end else begin
            // row end: right column past the edge is zero padding
            op_valid    = 1'b1;
            right_zero  = 1'b1;
            op_meta.col = ctl.col_o + 10'd1;
            phase_nxt   = 1'b0;
            q_pop       = 1'b1;
          end
          if (ctl.drain_start && q_pop) begin
            win_nxt[0] = '0;
            win_nxt[1] = '0;
            win_nxt[2] = '0;
            win_nxt[3] = c0a_r;
            win_nxt[4] = c0b_r;
            win_nxt[5] = '0;
          end
        end
        JOB_FLUSH: begin
          op_valid           = 1'b1;
          op_meta.frame_last = ctl.last;
          for (int k = 0; k < 3; k++) begin
            win_nxt[k]     = ctl.last ? '0 : win_r[3 + k];
            win_nxt[3 + k] = ctl.last ? '0 : dcol[k];
          end
          q_pop = 1'b1;
        end
        default: begin
          q_pop = 1'b1;
        end
      endcase
    end
  end

  // nine taps: left column, center column, incoming column
  for (genvar k = 0; k < NUM_COEFS; k++) begin : g_tap
    localparam int KY = k / 3;
    localparam int KX = k % 3;
    logic signed [SB-1:0] opnd;
    always_comb begin
      if (KX == 0) begin
        opnd = win_r[KY];
      end else if (KX == 1) begin
        opnd = win_r[3 + KY];
      end else begin
        opnd = right_zero ? '0 : dcol[KY];
      end
    end
    assign prod[k] = opnd * coef_r[k];
  end

  always_comb begin
    if (s_sum_r > SAT_HI) begin
      res_sat = 32'sh7FFF_FFFF;
    end else if (s_sum_r < SAT_LO) begin
      res_sat = 32'sh8000_0000;
    end else begin
      res_sat = s_sum_r[31:0];
    end
    if (cfg.relu_enable && res_sat[31]) begin
      res_sat = '0;
    end
  end

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      for (int k = 0; k < 6; k++) begin
        win_r[k] <= '0;
      end
      for (int k = 0; k < NUM_COEFS; k++) begin
        coef_r[k] <= '0;
      end
      phase_r     <= 1'b0;
      m_valid_r   <= 1'b0;
      p_valid_r   <= 1'b0;
      s_valid_r   <= 1'b0;
      out_valid_r <= 1'b0;
    end else begin
      win_r   <= win_nxt;
      coef_r  <= coef_nxt;
      phase_r <= phase_nxt;
      if (en) begin
        m_valid_r   <= op_valid;
        p_valid_r   <= m_valid_r;
        s_valid_r   <= p_valid_r;
        out_valid_r <= s_valid_r;
      end
    end
  end

  always_ff @(posedge clk) begin
    c0a_r <= c0a_nxt;
    c0b_r <= c0b_nxt;
    if (en) begin
      for (int k = 0; k < NUM_COEFS; k++) begin
        m_prod_r[k] <= prod[k];
      end
      m_meta_r <= op_meta;
      for (int j = 0; j < 3; j++) begin
        p_sum_r[j] <= PSW'(m_prod_r[3*j]) + PSW'(m_prod_r[3*j + 1])
                    + PSW'(m_prod_r[3*j + 2]);
      end
      p_meta_r   <= m_meta_r;
      s_sum_r    <= SW'($signed(cfg.bias_value)) + SW'(p_sum_r[0]) + SW'(p_sum_r[1])
                  + SW'(p_sum_r[2]);
      s_meta_r   <= p_meta_r;
      conv_r     <= res_sat;
      out_meta_r <= s_meta_r;
    end
  end

  assign out_chan.valid       = out_valid_r;
  assign out_chan.conv_result = conv_r;
  assign out_chan.out_row     = out_meta_r.row;
  assign out_chan.out_col     = out_meta_r.col;
  assign out_chan.run_last    = out_meta_r.run_last;
  assign out_chan.frame_last  = out_meta_r.frame_last;

endmodule
